/* design/jsu_pkg.sv */
package jsu_pkg;

	typedef enum logic [1:0] {
		MODE_PLAIN = 2'd0,
		MODE_ESC   = 2'd1,
		MODE_HEX   = 2'd2
	} mode_t;

	typedef enum logic [2:0] {
		KIND_DATA      = 3'd0,
		KIND_CLOSED    = 3'd1,
		KIND_BAD_ESC   = 3'd2,
		KIND_BAD_HEX   = 3'd3,
		KIND_TOO_LARGE = 3'd4,
		KIND_EOF       = 3'd5
	} kind_t;

	localparam int unsigned HexDigits = 4;
	localparam int unsigned CodeLimit = 256;
	localparam int unsigned CodeWidth = 16;

	localparam logic [7:0] CH_QUOTE     = 8'h22;
	localparam logic [7:0] CH_BACKSLASH = 8'h5c;
	localparam logic [7:0] CH_SLASH     = 8'h2f;
	localparam logic [7:0] CH_B         = 8'h62;
	localparam logic [7:0] CH_F         = 8'h66;
	localparam logic [7:0] CH_N         = 8'h6e;
	localparam logic [7:0] CH_R         = 8'h72;
	localparam logic [7:0] CH_T         = 8'h74;
	localparam logic [7:0] CH_U         = 8'h75;

	localparam logic [7:0] BS_CODE  = 8'h08;
	localparam logic [7:0] FF_CODE  = 8'h0c;
	localparam logic [7:0] LF_CODE  = 8'h0a;
	localparam logic [7:0] CR_CODE  = 8'h0d;
	localparam logic [7:0] TAB_CODE = 8'h09;

	typedef struct packed {
		logic       ok;
		logic [3:0] value;
	} hex_digit_t;

	function automatic hex_digit_t hex_value(input logic [7:0] b);
		hex_digit_t r;
		r.ok    = 1'b1;
		r.value = 4'd0;
		if (b >= 8'h30 && b <= 8'h39) begin
			r.value = 4'(b - 8'h30);
		end else if (b >= 8'h41 && b <= 8'h46) begin
			r.value = 4'(b - 8'h41 + 8'd10);
		end else if (b >= 8'h61 && b <= 8'h66) begin
			r.value = 4'(b - 8'h61 + 8'd10);
		end else begin
			r.ok = 1'b0;
		end
		return r;
	endfunction

endpackage

/* design/jsu_in_if.sv */
interface jsu_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       end_of_input;

	modport source (output valid, output in_byte, output end_of_input, input ready);
	modport sink (input valid, input in_byte, input end_of_input, output ready);
endinterface

/* design/jsu_out_if.sv */
interface jsu_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [2:0] kind;

	modport source (output valid, output out_byte, output kind, input ready);
	modport sink (input valid, input out_byte, input kind, output ready);
endinterface

/* design/json_string_unescape_core.sv */
// an accepted byte is held in the input register and moves to the result register when decode advances
// one byte per cycle when the result register does not stall, via a single decode stage
// bytes that produce no result (backslash, u, leading hex digits) still use the decode stage
// the result register stalls the decode stage while it holds an untaken transaction
// reset (arst_n low) empties both stages and returns the decoder to plain text mode
module json_string_unescape_core (
	input  logic            clk,
	input  logic            arst_n,
	jsu_in_if.sink          raw,
	jsu_out_if.source       result
);
	import jsu_pkg::*;

	logic                 vld_s1;
	logic [7:0]           byte_s1;
	logic                 eoi_s1;

	mode_t                mode_q;
	mode_t                mode_d;
	logic [1:0]           hex_cnt_q;
	logic [1:0]           hex_cnt_d;
	logic [CodeWidth-1:0] code_q;
	logic [CodeWidth-1:0] code_d;
	logic [CodeWidth-1:0] acc;
	hex_digit_t           hd;

	logic                 res_vld;
	logic [7:0]           res_byte;
	kind_t                res_kind;

	logic                 out_valid_q;
	logic [7:0]           out_byte_q;
	kind_t                out_kind_q;

	logic                 adv;
	logic                 take;

	assign adv       = vld_s1 && (!out_valid_q || result.ready);
	assign take      = raw.valid && raw.ready;
	assign raw.ready = !vld_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (take) begin
			vld_s1 <= 1'b1;
		end else if (adv) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			byte_s1 <= raw.in_byte;
			eoi_s1  <= raw.end_of_input;
		end
	end

	always_comb begin
		mode_d    = mode_q;
		hex_cnt_d = hex_cnt_q;
		code_d    = code_q;
		res_vld   = 1'b0;
		res_byte  = 8'd0;
		res_kind  = KIND_DATA;
		hd        = hex_value(byte_s1);
		acc       = {code_q[CodeWidth-5:0], hd.value};
		if (eoi_s1) begin
			mode_d    = MODE_PLAIN;
			hex_cnt_d = 2'd0;
			code_d    = '0;
			res_vld   = 1'b1;
			res_kind  = KIND_EOF;
		end else begin
			unique case (mode_q)
				MODE_ESC: begin
					mode_d  = MODE_PLAIN;
					res_vld = 1'b1;
					unique case (byte_s1)
						CH_QUOTE, CH_BACKSLASH, CH_SLASH: res_byte = byte_s1;
						CH_B: res_byte = BS_CODE;
						CH_F: res_byte = FF_CODE;
						CH_N: res_byte = LF_CODE;
						CH_R: res_byte = CR_CODE;
						CH_T: res_byte = TAB_CODE;
						CH_U: begin
							mode_d    = MODE_HEX;
							hex_cnt_d = 2'd0;
							code_d    = '0;
							res_vld   = 1'b0;
						end
						default: begin
							hex_cnt_d = 2'd0;
							code_d    = '0;
							res_kind  = KIND_BAD_ESC;
						end
					endcase
				end
				MODE_HEX: begin
					if (!hd.ok) begin
						mode_d    = MODE_PLAIN;
						hex_cnt_d = 2'd0;
						code_d    = '0;
						res_vld   = 1'b1;
						res_kind  = KIND_BAD_HEX;
					end else if (hex_cnt_q != 2'(HexDigits - 1)) begin
						hex_cnt_d = hex_cnt_q + 2'd1;
						code_d    = acc;
					end else begin
						mode_d    = MODE_PLAIN;
						hex_cnt_d = 2'd0;
						code_d    = '0;
						res_vld   = 1'b1;
						if (acc >= CodeWidth'(CodeLimit)) begin
							res_kind = KIND_TOO_LARGE;
						end else begin
							res_byte = acc[7:0];
						end
					end
				end
				default: begin
					// plain text; the unused mode code behaves the same
					if (byte_s1 == CH_QUOTE) begin
						mode_d    = MODE_PLAIN;
						hex_cnt_d = 2'd0;
						code_d    = '0;
						res_vld   = 1'b1;
						res_kind  = KIND_CLOSED;
					end else if (byte_s1 == CH_BACKSLASH) begin
						mode_d = MODE_ESC;
					end else begin
						mode_d   = MODE_PLAIN;
						res_vld  = 1'b1;
						res_byte = byte_s1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q    <= MODE_PLAIN;
			hex_cnt_q <= 2'd0;
			code_q    <= '0;
		end else if (adv) begin
			mode_q    <= mode_d;
			hex_cnt_q <= hex_cnt_d;
			code_q    <= code_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || result.ready) begin
			out_valid_q <= adv && res_vld;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && res_vld) begin
			out_byte_q <= res_byte;
			out_kind_q <= res_kind;
		end
	end

	assign result.valid    = out_valid_q;
	assign result.out_byte = out_byte_q;
	assign result.kind     = out_kind_q;

`ifndef SYNTH
	a_cnt_only_hex: assert property (@(posedge clk) disable iff (!arst_n)
		(hex_cnt_q != 2'd0) |-> (mode_q == MODE_HEX))
		else $error("hex digit count outside hex mode");

	a_byte_zero_non_data: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_kind_q != KIND_DATA) |-> (out_byte_q == 8'd0))
		else $error("status transaction carries a nonzero byte");

	a_eoi_reports: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && eoi_s1) |=> (out_valid_q && out_kind_q == KIND_EOF))
		else $error("end of input did not produce a result");

	a_no_adv_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !result.ready) |-> !adv)
		else $error("decode stage advanced over a held result");
`endif

endmodule
